// ===== hw/rtl/debounced_button_led_mode_breathe_macros.svh =====
// Assertion macros for the button/LED mode block and its checker.
// Every macro is clocked on clk_i and turned off while rst_ni is low.
`ifndef DEBOUNCED_BUTTON_LED_MODE_BREATHE_MACROS_SVH
`define DEBOUNCED_BUTTON_LED_MODE_BREATHE_MACROS_SVH

// The property must hold on every clock edge.
`define DBLMB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// If ante holds, cons must hold in the following cycle.
`define DBLMB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dblmb_pkg.sv =====
// Shared types and constants for the debounced button / LED mode block.
// No dependencies.
package dblmb_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [DutyW-1:0]  DutyTop  = '1;

  // register indexes (paddr[3:2])
  localparam logic [1:0] RegDebounce = 2'd0;
  localparam logic [1:0] RegInterval = 2'd1;
  localparam logic [1:0] RegMidDuty  = 2'd2;
  localparam logic [1:0] RegMaxDuty  = 2'd3;

  localparam logic [CountW-1:0] DebounceRst = 16'd50;
  localparam logic [CountW-1:0] IntervalRst = 16'd10;
  localparam logic [DutyW-1:0]  MidDutyRst  = 8'd128;
  localparam logic [DutyW-1:0]  MaxDutyRst  = 8'd255;

  // LED modes
  localparam logic [ModeW-1:0] ModeOff     = 2'd0;
  localparam logic [ModeW-1:0] ModeMid     = 2'd1;
  localparam logic [ModeW-1:0] ModeMax     = 2'd2;
  localparam logic [ModeW-1:0] ModeBreathe = 2'd3;

  typedef struct packed {
    logic [CountW-1:0] debounce_ticks;
    logic [CountW-1:0] breathe_interval_ticks;
    logic [DutyW-1:0]  mid_duty;
    logic [DutyW-1:0]  max_duty;
  } cfg_t;

  // mode after this tick's debounce, and whether a press changed it
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             changed;
  } mode_upd_t;

endpackage

// ===== hw/rtl/dblmb_regs.sv =====
// APB register file: debounce time, ramp interval and the two fixed duties.
// Depends on dblmb_pkg.
module dblmb_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [dblmb_pkg::AddrW-1:0] paddr,
  input  logic [dblmb_pkg::DataW-1:0] pwdata,
  output logic [dblmb_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output dblmb_pkg::cfg_t           cfg_o
);
  import dblmb_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegDebounce: cfg_d.debounce_ticks         = pwdata[CountW-1:0];
        RegInterval: cfg_d.breathe_interval_ticks = pwdata[CountW-1:0];
        RegMidDuty:  cfg_d.mid_duty               = pwdata[DutyW-1:0];
        RegMaxDuty:  cfg_d.max_duty               = pwdata[DutyW-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegDebounce: prdata = {{(DataW-CountW){1'b0}}, cfg_q.debounce_ticks};
      RegInterval: prdata = {{(DataW-CountW){1'b0}}, cfg_q.breathe_interval_ticks};
      RegMidDuty:  prdata = {{(DataW-DutyW){1'b0}}, cfg_q.mid_duty};
      RegMaxDuty:  prdata = {{(DataW-DutyW){1'b0}}, cfg_q.max_duty};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks         <= DebounceRst;
      cfg_q.breathe_interval_ticks <= IntervalRst;
      cfg_q.mid_duty               <= MidDutyRst;
      cfg_q.max_duty               <= MaxDutyRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/dblmb_debounce.sv =====
// Button debouncer and mode counter: a settled press advances the mode.
// Depends on dblmb_pkg.
module dblmb_debounce (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic                        level_i,
  input  logic [dblmb_pkg::CountW-1:0] debounce_ticks_i,
  output dblmb_pkg::mode_upd_t        upd_o
);
  import dblmb_pkg::*;

  logic              prev_q, prev_d;
  logic              settled_q, settled_d;
  logic [CountW-1:0] settle_q, settle_d;
  logic [ModeW-1:0]  mode_q, mode_d;
  logic              accept;
  logic              changed;

  always_comb begin
    if (level_i != prev_q) begin
      settle_d = '0;
    end else if (settle_q != CountMax) begin
      settle_d = settle_q + 1'b1;
    end else begin
      settle_d = settle_q;
    end
    accept    = (settle_d > debounce_ticks_i) && (level_i != settled_q);
    settled_d = accept ? level_i : settled_q;
    changed   = accept & ~level_i;
    mode_d    = mode_q + ModeW'(changed);
    prev_d    = level_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= 1'b1;
      settled_q <= 1'b1;
      settle_q  <= CountMax;
      mode_q    <= ModeOff;
    end else if (fire_i) begin
      prev_q    <= prev_d;
      settled_q <= settled_d;
      settle_q  <= settle_d;
      mode_q    <= mode_d;
    end
  end

  assign upd_o.mode    = mode_d;
  assign upd_o.changed = changed;

endmodule

// ===== hw/rtl/dblmb_ramp.sv =====
// Duty selection and triangle breathing ramp for the LED PWM.
// Depends on dblmb_pkg.
module dblmb_ramp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  dblmb_pkg::mode_upd_t       upd_i,
  input  dblmb_pkg::cfg_t            cfg_i,
  output logic [dblmb_pkg::DutyW-1:0] duty_o
);
  import dblmb_pkg::*;

  logic [DutyW-1:0]  duty_q, duty_d;
  logic [DutyW-1:0]  lvl_q, lvl_d;
  logic              rise_q, rise_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              breathe;

  assign breathe = (upd_i.mode == ModeBreathe);

  always_comb begin
    duty_d = duty_q;
    lvl_d  = lvl_q;
    rise_d = rise_q;
    cnt_d  = cnt_q;
    if (upd_i.changed) begin
      unique case (upd_i.mode)
        ModeOff:     duty_d = '0;
        ModeMid:     duty_d = cfg_i.mid_duty;
        ModeMax:     duty_d = cfg_i.max_duty;
        ModeBreathe: begin
          lvl_d  = '0;
          rise_d = 1'b1;
          cnt_d  = '0;
        end
        default:     duty_d = duty_q;
      endcase
    end else if (breathe && cnt_q != CountMax) begin
      cnt_d = cnt_q + 1'b1;
    end

    // ramp step; turns around at both ends
    if (breathe && cnt_d >= cfg_i.breathe_interval_ticks) begin
      cnt_d = '0;
      if (rise_d) begin
        if (lvl_d >= DutyTop - 1'b1) begin
          lvl_d  = DutyTop;
          rise_d = 1'b0;
        end else begin
          lvl_d = lvl_d + 1'b1;
        end
      end else begin
        if (lvl_d <= DutyW'(1)) begin
          lvl_d  = '0;
          rise_d = 1'b1;
        end else begin
          lvl_d = lvl_d - 1'b1;
        end
      end
      duty_d = lvl_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q <= '0;
      lvl_q  <= '0;
      rise_q <= 1'b1;
      cnt_q  <= '0;
    end else if (fire_i) begin
      duty_q <= duty_d;
      lvl_q  <= lvl_d;
      rise_q <= rise_d;
      cnt_q  <= cnt_d;
    end
  end

  assign duty_o = duty_d;

endmodule

// ===== hw/rtl/debounced_button_led_mode_breathe.sv =====
// Debounced button that steps an LED through off, mid, max and breathing
// modes. One request is one 1 ms tick with the raw button level; one result
// comes out per tick. A tick is captured in an input register, goes through
// the combinational debounce and duty logic and lands in the output register,
// so a new tick is taken every cycle while the output is not blocked. Ticks
// stall only while the output register is full and not taken. Registers:
// 0x0 debounce_ticks, 0x4 breathe_interval_ticks, 0x8 mid_duty, 0xC max_duty.
// Depends on dblmb_pkg, dblmb_regs, dblmb_debounce and dblmb_ramp.
module debounced_button_led_mode_breathe (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [0] button_level
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata,  // [7:0] pwm_duty, [9:8] led_mode,
                                                     // [10] mode_changed
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dblmb_pkg::AddrW-1:0] paddr,
  input  logic [dblmb_pkg::DataW-1:0] pwdata,
  output logic [dblmb_pkg::DataW-1:0] prdata,
  output logic                        pready
);
  import dblmb_pkg::*;

  cfg_t             cfg;
  mode_upd_t        upd;
  logic [DutyW-1:0] duty;

  logic             in_vld_q;
  logic             level_q;
  logic             out_vld_q;
  logic [DutyW-1:0] out_duty_q;
  logic [ModeW-1:0] out_mode_q;
  logic             out_chg_q;
  logic             fire;

  assign fire          = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | fire;

  dblmb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dblmb_debounce u_debounce (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fire_i           (fire),
    .level_i          (level_q),
    .debounce_ticks_i (cfg.debounce_ticks),
    .upd_o            (upd)
  );

  dblmb_ramp u_ramp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .upd_i  (upd),
    .cfg_i  (cfg),
    .duty_o (duty)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      level_q <= s_axis_tdata[0];
    end
    if (fire) begin
      out_duty_q <= duty;
      out_mode_q <= upd.mode;
      out_chg_q  <= upd.changed;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, out_chg_q, out_mode_q, out_duty_q};

endmodule

// ===== hw/rtl/dblmb_checker.sv =====
// Port-level checker for debounced_button_led_mode_breathe, bound to the top.
// Depends on dblmb_pkg and the assertion macro header.
`include "debounced_button_led_mode_breathe_macros.svh"

module dblmb_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [7:0]                  s_axis_tdata,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [15:0]                 m_axis_tdata,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [dblmb_pkg::AddrW-1:0] paddr,
  input logic [dblmb_pkg::DataW-1:0] pwdata,
  input logic [dblmb_pkg::DataW-1:0] prdata,
  input logic                        pready
);
  import dblmb_pkg::*;

  `DBLMB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed or dropped")

  // input side stalls only when the output register is full and blocked
  `DBLMB_ASSERT(a_stall_cause, !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready), "input stalled without output backpressure")

  // off mode always drives zero duty
  `DBLMB_ASSERT(a_off_dark, (m_axis_tvalid && m_axis_tdata[9:8] == ModeOff) |-> (m_axis_tdata[7:0] == 8'd0), "nonzero duty in off mode")

  `DBLMB_ASSERT(a_pready, pready, "pready dropped")

endmodule

bind debounced_button_led_mode_breathe dblmb_checker u_dblmb_checker (.*);
